// ----- rtl/sfb_pkg.sv -----
// sfb_pkg: shared types, controller byte constants and segment lookup
// for the four-digit segment frame builder; no dependencies
package sfb_pkg;

	// request transaction
	typedef struct packed {
		logic [6:0] left_value;
		logic       left_show;
		logic [6:0] right_value;
		logic       right_show;
		logic       colon_on;
	} req_t;

	// framed controller byte transaction
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       start_before;
		logic       stop_after;
		logic       last_byte;
	} frm_t;

	// four segment codes, digit 0 is the leftmost
	typedef logic [3:0][7:0] seg_set_t;

	// step count of one frame
	localparam int unsigned FRAME_LEN = 10;
	typedef logic [3:0] step_t;

	localparam step_t STEP_FIRST = 4'd0;
	localparam step_t STEP_LAST  = 4'(FRAME_LEN - 1);

	// controller bytes
	localparam logic [7:0] CMD_AUTO_INC   = 8'h44;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
	localparam logic [7:0] ADDR_BASE      = 8'hc0;
	localparam logic [7:0] POINT_BIT      = 8'h80;
	localparam logic [7:0] SEG_BLANK      = 8'h00;

	localparam logic [6:0] VALUE_MAX = 7'd99;

	// digit to segment code, bit 0 is segment a, bit 6 segment g
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'h3f;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5b;
			4'd3: code = 8'h4f;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6d;
			4'd6: code = 8'h7d;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7f;
			4'd9: code = 8'h6f;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/sfb_front.sv -----
// sfb_front: accepts request transactions, saturates and splits values,
// looks up segment codes; depends on sfb_pkg
module sfb_front (
	input  sfb_pkg::req_t     req,
	output sfb_pkg::seg_set_t segs
);
	import sfb_pkg::*;

	logic [6:0]  lv, rv;
	logic [14:0] lprod, rprod;
	logic [3:0]  ltens, lunits, rtens, runits;
	logic [7:0]  seg1;

	// saturate to two digits
	assign lv = (req.left_value  > VALUE_MAX) ? VALUE_MAX : req.left_value;
	assign rv = (req.right_value > VALUE_MAX) ? VALUE_MAX : req.right_value;

	// divide by ten via reciprocal, exact below 100
	assign lprod  = 15'(lv) * 15'd205;
	assign rprod  = 15'(rv) * 15'd205;
	assign ltens  = lprod[14:11];
	assign rtens  = rprod[14:11];
	assign lunits = 4'(lv - 7'({ltens, 3'b000}) - 7'({ltens, 1'b0}));
	assign runits = 4'(rv - 7'({rtens, 3'b000}) - 7'({rtens, 1'b0}));

	// segment codes, hidden pairs blank, colon on second digit
	assign seg1 = req.left_show ? seg_code(lunits) : SEG_BLANK;

	always_comb begin
		segs[0] = req.left_show  ? seg_code(ltens)  : SEG_BLANK;
		segs[1] = req.colon_on   ? (seg1 | POINT_BIT) : seg1;
		segs[2] = req.right_show ? seg_code(rtens)  : SEG_BLANK;
		segs[3] = req.right_show ? seg_code(runits) : SEG_BLANK;
	end

endmodule

// ----- rtl/sfb_queue.sv -----
// sfb_queue: short fifo of segment sets between front and back;
// depends on sfb_pkg
module sfb_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfb_pkg::seg_set_t push_data,
	input  logic              pop,
	output sfb_pkg::seg_set_t head,
	output logic              full,
	output logic              empty
);
	import sfb_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	seg_set_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count above depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_full_empty_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue full and empty at once");

endmodule

// ----- rtl/sfb_back.sv -----
// sfb_back: walks the ten-byte frame for the queue head into a
// registered output; depends on sfb_pkg
module sfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sfb_pkg::seg_set_t head,
	input  logic              empty,
	output logic              pop,
	output logic              frm_valid,
	input  logic              frm_stall,
	output sfb_pkg::frm_t     frm_data
);
	import sfb_pkg::*;

	step_t step_q;
	logic  frm_valid_q;
	frm_t  frm_data_q;
	logic  load;
	frm_t  next_byte;

	// output register takes a new byte when it is empty or being drained and the queue is not empty
	assign load = !empty && (!frm_valid_q || !frm_stall);
	assign pop  = load && (step_q == STEP_LAST);

	// byte and framing for the current step
	always_comb begin
		next_byte = '0;
		case (step_q)
			4'd0: next_byte = '{CMD_AUTO_INC, 1'b1, 1'b1, 1'b0};
			4'd1: next_byte = '{ADDR_BASE | 8'h00, 1'b1, 1'b0, 1'b0};
			4'd2: next_byte = '{head[0], 1'b0, 1'b1, 1'b0};
			4'd3: next_byte = '{ADDR_BASE | 8'h01, 1'b1, 1'b0, 1'b0};
			4'd4: next_byte = '{head[1], 1'b0, 1'b1, 1'b0};
			4'd5: next_byte = '{ADDR_BASE | 8'h02, 1'b1, 1'b0, 1'b0};
			4'd6: next_byte = '{head[2], 1'b0, 1'b1, 1'b0};
			4'd7: next_byte = '{ADDR_BASE | 8'h03, 1'b1, 1'b0, 1'b0};
			4'd8: next_byte = '{head[3], 1'b0, 1'b1, 1'b0};
			4'd9: next_byte = '{CMD_DISPLAY_ON, 1'b1, 1'b1, 1'b1};
			default: next_byte = '0;
		endcase
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FIRST;
			frm_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= (step_q == STEP_LAST) ? STEP_FIRST : step_q + 1'b1;
				frm_valid_q <= 1'b1;
			end else if (!frm_stall) begin
				frm_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			frm_data_q <= next_byte;
		end
	end

	assign frm_valid = frm_valid_q;
	assign frm_data  = frm_data_q;

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(frm_valid_q && frm_data_q.last_byte) |-> (step_q == STEP_FIRST))
		else $error("step counter not at frame start after last byte");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != STEP_FIRST) |-> !empty)
		else $error("queue head lost in the middle of a frame");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("step counter out of range");

endmodule

// ----- rtl/four_digit_segment_frame_builder.sv -----
// four_digit_segment_frame_builder: top level, front decode, segment queue
// and frame sequencer; depends on sfb_pkg, sfb_front, sfb_queue, sfb_back
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_stall | sfb_pkg::req_t (values, shows, colon)
//   frm     | out | frm_valid / frm_stall | sfb_pkg::frm_t (byte and framing)
//
// each request yields ten bytes, one per cycle without output stall.
// requests are decoded in the accept cycle and wait in a QUEUE_DEPTH deep
// queue, so the next request is taken while the current frame still runs.
// reset clears queue pointers and fill count, step counter and output valid.
// req_stall rises only while the queue is full; frm_stall holds the output
// register and the step counter.
module four_digit_segment_frame_builder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sfb_pkg::req_t req_data,
	output logic          frm_valid,
	input  logic          frm_stall,
	output sfb_pkg::frm_t frm_data
);
	import sfb_pkg::*;

	seg_set_t segs, head;
	logic     q_full, q_empty, q_pop;

	// decode requests
	sfb_front u_front (
		.req  (req_data),
		.segs (segs)
	);

	// decoupling queue
	sfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_valid),
		.push_data (segs),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign req_stall = q_full;

	// frame sequencer
	sfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (q_pop),
		.frm_valid (frm_valid),
		.frm_stall (frm_stall),
		.frm_data  (frm_data)
	);

endmodule
